// ===== hw/rtl/bpa_pkg.sv =====
// Shared constants, types and helper functions of the block padding adder.
package bpa_pkg;

  localparam int MAX_BLOCK = 16;
  localparam int POS_W     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int EB_W      = $clog2(MAX_BLOCK + 1);
  localparam int BLK_W     = 5;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 32;
  localparam int ADDR_W    = 2;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic [ADDR_W-1:0] CFG_PAD_MODE    = 2'd0;
  localparam logic [ADDR_W-1:0] CFG_BLOCK_BYTES = 2'd1;
  localparam logic [ADDR_W-1:0] CFG_FILLER_SEED = 2'd2;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    PAD_ZERO  = 2'd0,
    PAD_ANSI  = 2'd1,
    PAD_PKCS7 = 2'd2,
    PAD_ISO   = 2'd3
  } pad_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REM,
    ST_HELD,
    ST_PAD
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept_data;
    logic load_rem;
    logic sub_rem;
    logic load_pad;
    logic emit_held;
    logic emit_pad;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic held_valid;
    logic rem_ge_bs;
    logic p_zero;
    logic cnt_zero;
    logic cnt_last;
  } dp_sts_t;

  function automatic logic [EB_W-1:0] eff_block(input logic [BLK_W-1:0] b);
    logic [EB_W-1:0] r;
    if (b == '0) begin
      r = EB_W'(1);
    end else if (int'(b) > MAX_BLOCK) begin
      r = EB_W'(MAX_BLOCK);
    end else begin
      r = EB_W'(b);
    end
    return r;
  endfunction

  // Eight Galois steps; filler byte is the low byte of the result
  function automatic logic [31:0] lfsr_byte(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/bpa_ctrl.sv =====
// Controller state machine: sequences message bytes, remainder and padding output.
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              opcode,
  input  bpa_pkg::dp_sts_t  sts,
  output bpa_pkg::dp_cmd_t  cmd
);

  bpa_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      bpa_pkg::ST_IDLE: begin
        in_tready = sts.out_free;
        if (in_tvalid && sts.out_free) begin
          if (opcode == bpa_pkg::OP_DATA) begin
            cmd.accept_data = 1'b1;
          end else begin
            cmd.load_rem = 1'b1;
            state_nxt    = bpa_pkg::ST_REM;
          end
        end
      end
      bpa_pkg::ST_REM: begin
        // reduce position modulo block size, one subtraction a cycle
        if (sts.rem_ge_bs) begin
          cmd.sub_rem = 1'b1;
        end else begin
          cmd.load_pad = 1'b1;
          if (sts.held_valid) begin
            state_nxt = bpa_pkg::ST_HELD;
          end else if (!sts.p_zero) begin
            state_nxt = bpa_pkg::ST_PAD;
          end else begin
            state_nxt = bpa_pkg::ST_IDLE;
          end
        end
      end
      bpa_pkg::ST_HELD: begin
        if (sts.out_free) begin
          cmd.emit_held = 1'b1;
          state_nxt     = sts.cnt_zero ? bpa_pkg::ST_IDLE : bpa_pkg::ST_PAD;
        end
      end
      bpa_pkg::ST_PAD: begin
        if (sts.out_free) begin
          cmd.emit_pad = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = bpa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = bpa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bpa_dp.sv =====
// Datapath: configuration, held byte, block position, pad counter, LFSR, output register.
module bpa_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bpa_pkg::ADDR_W-1:0]      cfg_addr,
  input  logic [bpa_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [7:0]                      data_byte,
  input  bpa_pkg::dp_cmd_t                cmd,
  output bpa_pkg::dp_sts_t                sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);

  localparam int POS_W = bpa_pkg::POS_W;
  localparam int EB_W  = bpa_pkg::EB_W;

  bpa_pkg::pad_mode_t          mode_r;
  logic [bpa_pkg::BLK_W-1:0]   blk_r;
  logic [31:0]                 lfsr_r;
  logic [7:0]                  held_byte_r;
  logic                        held_valid_r;
  logic [POS_W-1:0]            pos_r;
  logic [POS_W-1:0]            rem_r;
  logic [EB_W-1:0]             p_r;
  logic [EB_W-1:0]             cnt_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_pad_r;
  logic                        out_last_r;

  logic [EB_W-1:0]  bs;
  logic [EB_W-1:0]  pos_inc;
  logic [EB_W-1:0]  rem_ext;
  logic [EB_W-1:0]  p_calc;
  logic [31:0]      lfsr_nxt;
  logic [7:0]       pad_byte;
  logic             out_free;
  logic             pad_final;

  assign bs        = bpa_pkg::eff_block(blk_r);
  assign pos_inc   = EB_W'(pos_r) + EB_W'(1);
  assign rem_ext   = EB_W'(rem_r);
  assign out_free  = !out_valid_r || out_tready;
  assign pad_final = (cnt_r == EB_W'(1));
  assign lfsr_nxt  = bpa_pkg::lfsr_byte(lfsr_r);

  always_comb begin
    if (rem_ext == '0) begin
      p_calc = (mode_r == bpa_pkg::PAD_ZERO) ? '0 : bs;
    end else begin
      p_calc = bs - rem_ext;
    end
  end

  always_comb begin
    case (mode_r)
      bpa_pkg::PAD_ZERO:  pad_byte = 8'd0;
      bpa_pkg::PAD_ANSI:  pad_byte = pad_final ? 8'(p_r) : 8'd0;
      bpa_pkg::PAD_PKCS7: pad_byte = 8'(p_r);
      bpa_pkg::PAD_ISO:   pad_byte = pad_final ? 8'(p_r) : lfsr_nxt[7:0];
      default:            pad_byte = 8'd0;
    endcase
  end

  always_comb begin
    sts.out_free   = out_free;
    sts.held_valid = held_valid_r;
    sts.rem_ge_bs  = (rem_ext >= bs);
    sts.p_zero     = (p_calc == '0);
    sts.cnt_zero   = (cnt_r == '0);
    sts.cnt_last   = pad_final;
  end

  // configuration and LFSR
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bpa_pkg::PAD_PKCS7;
      blk_r  <= bpa_pkg::BLK_W'(16);
      lfsr_r <= 32'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          bpa_pkg::CFG_PAD_MODE:
            mode_r <= bpa_pkg::pad_mode_t'(cfg_wdata[bpa_pkg::MODE_W-1:0]);
          bpa_pkg::CFG_BLOCK_BYTES:
            blk_r <= cfg_wdata[bpa_pkg::BLK_W-1:0];
          bpa_pkg::CFG_FILLER_SEED:
            lfsr_r <= (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.emit_pad && !pad_final && mode_r == bpa_pkg::PAD_ISO) begin
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  // message state and pad counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_byte_r  <= '0;
      pos_r        <= '0;
      rem_r        <= '0;
      p_r          <= '0;
      cnt_r        <= '0;
    end else begin
      if (cmd.accept_data) begin
        held_byte_r  <= data_byte;
        held_valid_r <= 1'b1;
        pos_r        <= (pos_inc >= bs) ? '0 : POS_W'(pos_inc);
      end
      if (cmd.load_rem) begin
        rem_r <= pos_r;
        pos_r <= '0;
      end
      if (cmd.sub_rem) begin
        rem_r <= POS_W'(rem_ext - bs);
      end
      if (cmd.load_pad) begin
        p_r   <= p_calc;
        cnt_r <= p_calc;
      end
      if (cmd.emit_held) begin
        held_valid_r <= 1'b0;
      end
      if (cmd.emit_pad) begin
        cnt_r <= cnt_r - EB_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_held || cmd.emit_pad || (cmd.accept_data && held_valid_r)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_data && held_valid_r) begin
      out_byte_r <= held_byte_r;
      out_pad_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (cmd.emit_held) begin
      out_byte_r <= held_byte_r;
      out_pad_r  <= 1'b0;
      out_last_r <= (cnt_r == '0);
    end else if (cmd.emit_pad) begin
      out_byte_r <= pad_byte;
      out_pad_r  <= 1'b1;
      out_last_r <= pad_final;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_pad_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/block_padding_adder.sv =====
// Top level of the block padding adder: controller plus datapath.
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata: data_byte[7:0]; tuser: opcode
//  out_     master     out_tvalid/out_tready tdata: out_byte[7:0]; tuser: is_padding;
//                                            tlast: last
//  cfg_     write      cfg_we               cfg_addr index, cfg_wdata value
//
// A message byte is held in the datapath; its predecessor leaves through the output register.
// An end item is accepted, then the block position is reduced by subtracting the block
// size (no subtraction when the position is below the block size), then the emitted
// bytes follow: the held byte and 0 to MAX_BLOCK pad bytes.
// Reset is synchronous, active low; it restores mode PKCS7, block 16, seed 1.
// A stalled output holds the output register and blocks further input.
module block_padding_adder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // data_byte[7:0]
  input  logic                        in_tuser,   // opcode
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // out_byte[7:0]
  output logic                        out_tuser,  // is_padding
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic [bpa_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [bpa_pkg::CFG_W-1:0]   cfg_wdata
);

  bpa_pkg::dp_cmd_t cmd;
  bpa_pkg::dp_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .opcode    (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .data_byte  (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
